// ----- rtl/egcd_pkg.sv -----
// Package for the extended Euclid / modular inverse unit: word types,
// widths, status codes and sequencer states. No dependencies.
package egcd_pkg;

    localparam int OP_W  = 63;  // operand and gcd width
    localparam int CO_W  = 64;  // signed coefficient width
    localparam int CNT_W = 6;   // quotient bit index, up to OP_W-1

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_INV  = 2'd1,
        STATUS_MOD_ZERO = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_ALIGN,
        ST_DIVIDE,
        ST_UPDATE,
        ST_REDUCE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic            action;     // 0 = gcd + Bezout, 1 = inverse mod b
        logic [OP_W-1:0] operand_a;
        logic [OP_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [OP_W-1:0]        gcd_value;
        logic signed [CO_W-1:0] coef_x;
        logic signed [CO_W-1:0] coef_y;
        logic [OP_W-1:0]        inverse;
        logic [1:0]             status;
    } out_word_t;

endpackage

// ----- rtl/extended_gcd_mod_inverse_unit.sv -----
// Extended Euclid unit: gcd, Bezout coefficients and modular inverse.
// Depends on egcd_pkg (word types, status codes, sequencer states).
//
// Usage
//   in channel:  in_valid / in_stall / in_word (action, operand_a, operand_b).
//   out channel: out_valid / out_stall / out_word (gcd_value, coef_x, coef_y,
//   inverse, status). A word moves when valid is high and stall is low.
//   One input word gives exactly one output word.
//
// Timing
//   One word at a time. in_stall is low only in the idle state. Each Euclid
//   step runs on one shared compare/subtract unit: an align pass shifts the
//   divisor up one quotient bit at a time, a restoring divide pass makes
//   one quotient bit per cycle while the s/t products q*s1, q*t1 build up
//   by shift-and-add, then an update step. After the last step come the
//   inverse reduction (repeated subtraction of the modulus) and output load.
//
// Reset and stall
//   rst_n (async, active low) returns the sequencer to idle and drops
//   out_valid. The result sits in an output register; while out_stall holds
//   it, a new word may already be taken and worked on, and it waits in the
//   emit state until the output register frees up.
// Status: 2 = modulus zero, 1 = gcd not one (no inverse); inverse is 0 then.
module extended_gcd_mod_inverse_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  egcd_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output egcd_pkg::out_word_t out_word
);
    import egcd_pkg::*;

    state_t state_reg, state_next;

    // Euclid state: remainders and coefficient pairs
    logic            act_reg, act_next;
    logic [OP_W-1:0] mod_reg, mod_next;          // original b
    logic [OP_W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [CO_W-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [CO_W-1:0] t0_reg, t0_next, t1_reg, t1_next;

    // shared divider
    logic [OP_W-1:0] rem_reg, rem_next;
    logic [OP_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CO_W-1:0] ps_reg, ps_next, pt_reg, pt_next;  // q*s1, q*t1

    // inverse reduction
    logic [CO_W-1:0] red_reg, red_next;
    logic            neg_reg, neg_next;

    out_word_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic            grow_ok;      // divisor can double and stay <= remainder
    logic            qbit;
    logic [OP_W:0]   rem_diff;
    logic            red_more;
    logic            inv_wanted;
    logic            out_free;
    logic [CO_W-1:0] red_diff;

    assign grow_ok    = ({div_reg, 1'b0} <= {1'b0, rem_reg});
    assign rem_diff   = {1'b0, rem_reg} - {1'b0, div_reg};
    assign qbit       = ~rem_diff[OP_W];
    assign inv_wanted = act_reg && (mod_reg != '0) && (r0_reg == OP_W'(1));
    assign red_diff   = red_reg - {1'b0, mod_reg};
    assign red_more   = inv_wanted && (red_reg >= {1'b0, mod_reg});
    assign out_free   = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOOP;
            ST_LOOP:   state_next = (r1_reg == '0) ? ST_REDUCE : ST_ALIGN;
            ST_ALIGN:  if (!grow_ok) state_next = ST_DIVIDE;
            ST_DIVIDE: if (k_reg == '0) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_LOOP;
            ST_REDUCE: if (!red_more) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = out_valid_reg;
        out_word  = out_reg;
    end

    // datapath
    always_comb
    begin
        act_next = act_reg;
        mod_next = mod_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        k_next   = k_reg;
        ps_next  = ps_reg;
        pt_next  = pt_reg;
        red_next = red_reg;
        neg_next = neg_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = in_word.action;
                    mod_next = in_word.operand_b;
                    r0_next  = in_word.operand_a;
                    r1_next  = in_word.operand_b;
                    s0_next  = CO_W'(1);
                    s1_next  = '0;
                    t0_next  = '0;
                    t1_next  = CO_W'(1);
                end
            end
            ST_LOOP:
            begin
                // start a division step, or the inverse fold-in when done
                rem_next = r0_reg;
                div_next = r1_reg;
                k_next   = '0;
                ps_next  = '0;
                pt_next  = '0;
                neg_next = s0_reg[CO_W-1];
                red_next = s0_reg[CO_W-1] ? (CO_W'(0) - s0_reg) : s0_reg;
            end
            ST_ALIGN:
            begin
                if (grow_ok)
                begin
                    div_next = {div_reg[OP_W-2:0], 1'b0};
                    k_next   = k_reg + CNT_W'(1);
                end
            end
            ST_DIVIDE:
            begin
                if (qbit)
                    rem_next = rem_diff[OP_W-1:0];
                div_next = {1'b0, div_reg[OP_W-1:1]};
                ps_next  = {ps_reg[CO_W-2:0], 1'b0} + (qbit ? s1_reg : '0);
                pt_next  = {pt_reg[CO_W-2:0], 1'b0} + (qbit ? t1_reg : '0);
                if (k_reg != '0)
                    k_next = k_reg - CNT_W'(1);
            end
            ST_UPDATE:
            begin
                r0_next = r1_reg;
                r1_next = rem_reg;
                s0_next = s1_reg;
                s1_next = s0_reg - ps_reg;
                t0_next = t1_reg;
                t1_next = t0_reg - pt_reg;
            end
            ST_REDUCE:
            begin
                if (red_more)
                    red_next = red_diff;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.gcd_value = r0_reg;
                    out_next.coef_x    = s0_reg;
                    out_next.coef_y    = t0_reg;
                    out_next.inverse   = '0;
                    out_next.status    = STATUS_OK;
                    if (act_reg)
                    begin
                        if (mod_reg == '0)
                            out_next.status = STATUS_MOD_ZERO;
                        else if (r0_reg != OP_W'(1))
                            out_next.status = STATUS_NO_INV;
                        else if (neg_reg && (red_reg != '0))
                            out_next.inverse = mod_reg - red_reg[OP_W-1:0];
                        else if (!neg_reg)
                            out_next.inverse = red_reg[OP_W-1:0];
                    end
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        mod_reg <= mod_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        k_reg   <= k_next;
        ps_reg  <= ps_next;
        pt_reg  <= pt_next;
        red_reg <= red_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for extended_gcd_mod_inverse_unit: gcd, Bezout
// coefficients and modular inverse, compared against an in-bench Euclid solver.
// Depends on egcd_pkg (word types, status codes) and the unit's RTL.
module tb;
    import egcd_pkg::*;

    localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};
    // consecutive Fibonacci numbers: the longest Euclid chain that fits 63 bits
    localparam logic [OP_W-1:0] FIB_92 = 63'd7540113804746346429;
    localparam logic [OP_W-1:0] FIB_91 = 63'd4660046610375530309;

    localparam int RANDOM_WORDS  = 117;
    localparam int DRAIN_CYCLES  = 800;     // longer than one full 63-bit item
    localparam int BACKLOG_HOLD  = 3000;    // out_stall stretch that fills the unit
    localparam int LIMIT_CYCLES  = 600000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    extended_gcd_mod_inverse_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // Directed row: operands plus, where it is obvious, the answer typed in.
    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t known;
    } plan_row_t;

    plan_row_t plan[$];
    out_word_t solutions_due[$];    // answers for accepted words, oldest first
    int        faults = 0;
    int        results_seen = 0;
    int        burst_left = 1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("tb failed");
        $finish;
    end

    // Iterative extended Euclid on 64-bit two's complement coefficients.
    // Wraparound in q*s1 and q*t1 is harmless: true values stay in range.
    function automatic out_word_t solve_bezout(input in_word_t w);
        logic [63:0] r0, r1, s0, s1, t0, t1;
        logic [63:0] q, nxt, modulus, mag, inv;
        out_word_t   o;
        r0 = {1'b0, w.operand_a};
        r1 = {1'b0, w.operand_b};
        s0 = 64'd1;
        s1 = 64'd0;
        t0 = 64'd0;
        t1 = 64'd1;
        while (r1 != 64'd0)
        begin
            q   = r0 / r1;
            nxt = r0 - q * r1;  r0 = r1;  r1 = nxt;
            nxt = s0 - q * s1;  s0 = s1;  s1 = nxt;
            nxt = t0 - q * t1;  t0 = t1;  t1 = nxt;
        end
        o.gcd_value = r0[OP_W-1:0];
        o.coef_x    = s0;
        o.coef_y    = t0;
        o.inverse   = '0;
        o.status    = STATUS_OK;
        if (w.action)
        begin
            modulus = {1'b0, w.operand_b};
            if (modulus == 64'd0)
                o.status = STATUS_MOD_ZERO;
            else if (r0 != 64'd1)
                o.status = STATUS_NO_INV;
            else
            begin
                // negative x: fold its magnitude, then reflect into [0, m)
                if (s0[63])
                begin
                    mag = (-s0) % modulus;
                    inv = (mag == 64'd0) ? 64'd0 : modulus - mag;
                end
                else
                    inv = s0 % modulus;
                o.inverse = inv[OP_W-1:0];
            end
        end
        return o;
    endfunction

    task automatic add_row(input logic act, input logic [OP_W-1:0] a,
                           input logic [OP_W-1:0] b, input bit typed,
                           input logic [OP_W-1:0] g, input logic signed [CO_W-1:0] x,
                           input logic signed [CO_W-1:0] y, input logic [OP_W-1:0] inv,
                           input status_t st);
        plan_row_t r;
        r.w.action          = act;
        r.w.operand_a       = a;
        r.w.operand_b       = b;
        r.typed             = typed;
        r.known.gcd_value   = g;
        r.known.coef_x      = x;
        r.known.coef_y      = y;
        r.known.inverse     = inv;
        r.known.status      = st;
        plan.push_back(r);
    endtask

    // Offer one word until it is taken, log its answer, then pace the sender:
    // bursts of random length separated by random gaps of idle cycles.
    task automatic offer(input in_word_t w, input bit typed, input out_word_t known);
        int gap;
        in_word  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        solutions_due.push_back(typed ? known : solve_bezout(w));
        burst_left--;
        if (burst_left == 0)
        begin
            // now and then a long run with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic in_word_t random_word();
        in_word_t    w;
        logic [63:0] wide_a, wide_b;
        logic [63:0] factor;
        int          kind;
        w.action = 1'($urandom_range(0, 1));
        kind     = $urandom_range(0, 9);
        wide_a   = {$urandom, $urandom};
        wide_b   = {$urandom, $urandom};
        case (kind)
            0, 1, 2:
            begin
                wide_a = 64'($urandom_range(0, 1000));
                wide_b = 64'($urandom_range(0, 1000));
            end
            3, 4, 5: ;  // full width on both sides
            6:
            begin
                // shared factor: gcd above one, no inverse
                factor = 64'($urandom_range(2, 1000));
                wide_a = factor * 64'($urandom_range(0, 1 << 20));
                wide_b = factor * 64'($urandom_range(1, 1 << 20));
            end
            7:  wide_b = 64'($urandom_range(0, 1));
            8:  wide_a = 64'($urandom_range(0, 1));
            default:
            begin
                wide_a = 64'($urandom);
                wide_b = 64'($urandom);
            end
        endcase
        w.operand_a = wide_a[OP_W-1:0];
        w.operand_b = wide_b[OP_W-1:0];
        return w;
    endfunction

    // Sender: reset, directed table, random words, then drain and verdict.
    initial
    begin
        out_word_t none;
        none     = '0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;

        // answers read straight off the algorithm
        add_row(1'b0, '0, '0, 1'b1, '0, 64'sd1, 64'sd0, '0, STATUS_OK);
        add_row(1'b0, OP_MAX, '0, 1'b1, OP_MAX, 64'sd1, 64'sd0, '0, STATUS_OK);
        add_row(1'b0, '0, 63'd5, 1'b1, 63'd5, 64'sd0, 64'sd1, '0, STATUS_OK);
        add_row(1'b0, OP_MAX, OP_MAX, 1'b1, OP_MAX, 64'sd0, 64'sd1, '0, STATUS_OK);
        add_row(1'b1, 63'd5, '0, 1'b1, 63'd5, 64'sd1, 64'sd0, '0, STATUS_MOD_ZERO);
        add_row(1'b1, '0, '0, 1'b1, '0, 64'sd1, 64'sd0, '0, STATUS_MOD_ZERO);
        add_row(1'b1, OP_MAX, '0, 1'b1, OP_MAX, 64'sd1, 64'sd0, '0, STATUS_MOD_ZERO);
        add_row(1'b1, 63'd6, 63'd4, 1'b1, 63'd2, 64'sd1, -64'sd1, '0, STATUS_NO_INV);
        add_row(1'b1, '0, 63'd7, 1'b1, 63'd7, 64'sd0, 64'sd1, '0, STATUS_NO_INV);
        add_row(1'b1, 63'd7, 63'd1, 1'b1, 63'd1, 64'sd0, 64'sd1, '0, STATUS_OK);
        add_row(1'b1, '0, 63'd1, 1'b1, 63'd1, 64'sd0, 64'sd1, '0, STATUS_OK);
        // the rest go through the solver
        add_row(1'b1, 63'd3, 63'd7, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, 63'd10, 63'd17, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, OP_MAX, OP_MAX - 63'd1, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, OP_MAX - 63'd1, OP_MAX, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, FIB_92, FIB_91, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b0, FIB_91, FIB_92, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b0, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 1'b0,
                '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, 63'h5555_5555_5555_5555, OP_MAX, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b0, 63'd1, OP_MAX, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, 63'd1, OP_MAX, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b1, 63'd2, 63'h4000_0000_0000_0000, 1'b0, '0, '0, '0, '0, STATUS_OK);
        add_row(1'b0, 63'd12, 63'd18, 1'b0, '0, '0, '0, '0, STATUS_OK);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer(plan[i].w, plan[i].typed, plan[i].known);
        for (int i = 0; i < RANDOM_WORDS; i++)
            offer(random_word(), 1'b0, none);

        in_valid <= 1'b0;
        while (solutions_due.size() != 0)
            @(posedge clk);
        // a stray extra word would show up in this window
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0 && solutions_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Receiver: checks each taken word against the oldest answer, and drives
    // out_stall on shifting patterns, with one long hold-off so that the unit
    // backs up and stalls its input while the sender keeps offering.
    initial
    begin
        out_word_t want;
        int        mode      = 0;
        int        mode_left = 50;
        int        hold_left = 0;
        int        cyc       = 0;
        bit        backlog_done = 0;
        logic      next_stall;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && out_valid && !out_stall)
            begin
                if (solutions_due.size() == 0)
                begin
                    $error("output word with no input word pending");
                    faults++;
                end
                else
                begin
                    want = solutions_due.pop_front();
                    results_seen++;
                    if (out_word.gcd_value !== want.gcd_value)
                    begin
                        $error("gcd_value: expected %0d, got %0d",
                               want.gcd_value, out_word.gcd_value);
                        faults++;
                    end
                    if (out_word.coef_x !== want.coef_x)
                    begin
                        $error("coef_x: expected %0d, got %0d",
                               want.coef_x, out_word.coef_x);
                        faults++;
                    end
                    if (out_word.coef_y !== want.coef_y)
                    begin
                        $error("coef_y: expected %0d, got %0d",
                               want.coef_y, out_word.coef_y);
                        faults++;
                    end
                    if (out_word.inverse !== want.inverse)
                    begin
                        $error("inverse: expected %0d, got %0d",
                               want.inverse, out_word.inverse);
                        faults++;
                    end
                    if (out_word.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, out_word.status);
                        faults++;
                    end
                end
            end

            if (!backlog_done && results_seen == 12)
            begin
                backlog_done = 1;
                hold_left    = BACKLOG_HOLD;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else
            begin
                mode_left--;
                if (mode_left <= 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                case (mode)
                    0:       next_stall = 1'b0;                         // free-flowing
                    1:       next_stall = ($urandom_range(0, 3) == 0);  // light
                    2:       next_stall = ($urandom_range(0, 3) != 0);  // heavy
                    default: next_stall = (cyc % 3 == 0);               // periodic
                endcase
            end
            out_stall <= next_stall;
        end
    end

endmodule
